// File: sv/running_mean_covariance_top_defines.svh
// Assertion macros for the running mean and covariance block.
`ifndef RUNNING_MEAN_COVARIANCE_TOP_DEFINES_SVH
`define RUNNING_MEAN_COVARIANCE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RMC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RMC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rmc_pkg.sv
// Shared types, constants and saturation helpers of the running mean and covariance block.
`default_nettype none
package rmc_pkg;
    localparam int NUM_COORDS = 6;
    localparam int NUM_PARAMS = 2;
    localparam int NUM_VALS   = NUM_COORDS + NUM_PARAMS;
    localparam int NUM_COV    = NUM_VALS * NUM_COORDS;
    localparam int NUM_STATS  = NUM_VALS + NUM_COV;
    localparam int STAT_AW    = $clog2(NUM_STATS);
    localparam int DEV_AW     = $clog2(NUM_VALS);
    localparam int COL_W      = $clog2(NUM_COORDS);
    localparam int VAL_W      = 18;
    localparam int STAT_W     = 48;
    localparam int DEV_W      = 32;
    localparam int CNT_W      = 32;
    localparam int IDX_W      = 6;
    localparam int DIV_W      = 50;
    localparam int DIV_CW     = $clog2(DIV_W + 1);

    typedef enum logic {
        OP_ACCUM,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                            op;
        logic [NUM_VALS-1:0][VAL_W-1:0] vals;
    } item_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_M_RD,
        BK_M_DIV,
        BK_M_WAIT,
        BK_C_ROW,
        BK_C_ROWL,
        BK_C_RD,
        BK_C_MUL,
        BK_C_D1,
        BK_C_W1,
        BK_C_D2,
        BK_C_W2,
        BK_R_ISSUE,
        BK_R_LOAD
    } back_state_t;

    // 53-bit signed to 48-bit signed, saturating
    function automatic logic signed [STAT_W-1:0] sat_stat(input logic signed [52:0] v);
        logic same;
        same = (&v[52:47]) || !(|v[52:47]);
        if (same)
            return v[STAT_W-1:0];
        else if (v[52])
            return {1'b1, {(STAT_W-1){1'b0}}};
        else
            return {1'b0, {(STAT_W-1){1'b1}}};
    endfunction

    // 50-bit signed to +-(2^31-1)
    function automatic logic signed [DEV_W-1:0] sat_dev(input logic signed [49:0] v);
        logic same;
        logic minval;
        same   = (&v[49:31]) || !(|v[49:31]);
        minval = v[31] && !(|v[30:0]);
        if (same && !minval)
            return v[DEV_W-1:0];
        else if (v[49])
            return {1'b1, {(DEV_W-2){1'b0}}, 1'b1};
        else
            return {1'b0, {(DEV_W-1){1'b1}}};
    endfunction
endpackage
`default_nettype wire

// File: sv/rmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rmc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 56,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: sv/rmc_div.sv
// Iterative restoring divider, one quotient bit per cycle, signed result from magnitudes.
`default_nettype none
module rmc_div import rmc_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DIV_W-1:0]        dividend,
    input  wire logic [CNT_W-1:0]        divisor,
    input  wire logic                    neg,
    output logic                         done,
    output logic signed [DIV_W:0]        quotient
);
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic [DIV_W:0]    quo_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = neg;
            cnt_next  = DIV_CW'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quo_ext  = {1'b0, quo_reg};
    assign quotient = neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
    assign done     = done_reg;
endmodule
`default_nettype wire

// File: sv/rmc_front.sv
// Input side: takes beats, classifies the command and holds them in a two-entry queue.
`default_nettype none
module rmc_front import rmc_pkg::*; (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           command,
    input  wire logic [NUM_VALS-1:0][VAL_W-1:0] vals,
    output logic                                q_valid,
    input  wire logic                           q_pop,
    output item_t                               q_item
);
    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;
    logic        pop;
    item_t       new_item;

    assign in_ready    = (fill_reg != 2'd2);
    assign q_valid     = (fill_reg != 2'd0);
    assign push        = in_valid && in_ready;
    assign pop         = q_pop && q_valid;
    assign q_item      = slot_reg[rd_ptr_reg];
    assign new_item.op   = command ? OP_READ : OP_ACCUM;
    assign new_item.vals = vals;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= new_item;
    end
endmodule
`default_nettype wire

// File: sv/rmc_back.sv
// Back end: sequencer over the statistics RAM, shared divider, multiplier and output register.
`default_nettype none
module rmc_back import rmc_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    output logic                          q_pop,
    input  wire item_t                    q_item,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [IDX_W-1:0]              stat_index,
    output logic signed [STAT_W-1:0]      stat_value,
    output logic [CNT_W-1:0]              sample_total,
    output logic                          last
);
    back_state_t                state_reg, state_next;
    item_t                      item_reg, item_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [DEV_AW-1:0]          k_reg, k_next;
    logic [DEV_AW-1:0]          row_reg, row_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [STAT_AW-1:0]         addr_reg, addr_next;
    logic signed [STAT_W-1:0]   old_reg, old_next;
    logic signed [DEV_W-1:0]    da_reg, da_next;
    logic signed [63:0]         prod_reg, prod_next;
    logic signed [STAT_W-1:0]   c_reg, c_next;
    logic signed [DIV_W:0]      t1_reg, t1_next;
    logic [NUM_STATS-1:0]       valid_reg, valid_next;
    logic                       rdv_reg;
    logic                       ov_reg, ov_next;
    logic [IDX_W-1:0]           oidx_reg;
    logic signed [STAT_W-1:0]   oval_reg;
    logic [CNT_W-1:0]           otot_reg;
    logic                       olast_reg;
    logic                       out_load;

    logic                       st_rd_en, st_wr_en;
    logic [STAT_AW-1:0]         st_rd_addr, st_wr_addr;
    logic [STAT_W-1:0]          st_wr_data, st_rd_data;
    logic signed [STAT_W-1:0]   stat_q;
    logic                       dv_rd_en, dv_wr_en;
    logic [DEV_AW-1:0]          dv_rd_addr, dv_wr_addr;
    logic [DEV_W-1:0]           dv_wr_data, dv_rd_data;

    logic                       div_start, div_done, div_neg;
    logic [DIV_W-1:0]           div_dividend;
    logic [CNT_W-1:0]           div_divisor;
    logic signed [DIV_W:0]      div_quot;

    logic signed [VAL_W-1:0]    x_cur;
    logic signed [49:0]         diff;
    logic [63:0]                prod_mag;
    logic [STAT_W:0]            c_mag;
    logic signed [STAT_W-1:0]   new_mean;
    logic signed [DEV_W-1:0]    dev_new;
    logic                       out_free;

    rmc_ram #(.WIDTH(STAT_W), .DEPTH(NUM_STATS)) u_stat_ram (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    rmc_ram #(.WIDTH(DEV_W), .DEPTH(NUM_VALS)) u_dev_ram (
        .clk     (clk),
        .wr_en   (dv_wr_en),
        .wr_addr (dv_wr_addr),
        .wr_data (dv_wr_data),
        .rd_en   (dv_rd_en),
        .rd_addr (dv_rd_addr),
        .rd_data (dv_rd_data)
    );

    rmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .neg      (div_neg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // entries never written read as zero
    assign stat_q   = rdv_reg ? $signed(st_rd_data) : '0;
    assign out_free = !ov_reg || out_ready;
    assign x_cur    = $signed(item_reg.vals[k_reg]);
    assign diff     = {{(50-VAL_W){x_cur[VAL_W-1]}}, x_cur} - {{2{stat_q[STAT_W-1]}}, stat_q};
    assign new_mean = sat_stat({{5{old_reg[STAT_W-1]}}, old_reg}
                               + {{2{div_quot[DIV_W]}}, div_quot});
    assign dev_new  = sat_dev({{(50-VAL_W){x_cur[VAL_W-1]}}, x_cur}
                              - {{2{new_mean[STAT_W-1]}}, new_mean});
    assign prod_mag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    assign c_mag    = c_reg[STAT_W-1] ? -{c_reg[STAT_W-1], c_reg} : {1'b0, c_reg};

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        addr_next    = addr_reg;
        old_next     = old_reg;
        da_next      = da_reg;
        prod_next    = prod_reg;
        c_next       = c_reg;
        t1_next      = t1_reg;
        valid_next   = valid_reg;
        q_pop        = 1'b0;
        out_load     = 1'b0;
        st_rd_en     = 1'b0;
        st_rd_addr   = addr_reg;
        st_wr_en     = 1'b0;
        st_wr_addr   = addr_reg;
        st_wr_data   = '0;
        dv_rd_en     = 1'b0;
        dv_rd_addr   = row_reg;
        dv_wr_en     = 1'b0;
        dv_wr_addr   = k_reg;
        dv_wr_data   = dev_new;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = n_reg;
        div_neg      = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.op == OP_READ)
                    begin
                        addr_next  = '0;
                        state_next = BK_R_ISSUE;
                    end
                    else
                    begin
                        cnt_next   = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
                        n_next     = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
                        k_next     = '0;
                        state_next = BK_M_RD;
                    end
                end
            end
            BK_M_RD:
            begin
                st_rd_en   = 1'b1;
                st_rd_addr = STAT_AW'(k_reg);
                state_next = BK_M_DIV;
            end
            BK_M_DIV:
            begin
                old_next     = stat_q;
                div_start    = 1'b1;
                div_dividend = diff[49] ? DIV_W'(-diff) : DIV_W'(diff);
                div_neg      = diff[49];
                state_next   = BK_M_WAIT;
            end
            BK_M_WAIT:
            begin
                if (div_done)
                begin
                    st_wr_en   = 1'b1;
                    st_wr_addr = STAT_AW'(k_reg);
                    st_wr_data = new_mean;
                    valid_next[STAT_AW'(k_reg)] = 1'b1;
                    dv_wr_en   = 1'b1;
                    if (k_reg == DEV_AW'(NUM_VALS - 1))
                    begin
                        if (n_reg < CNT_W'(2))
                            state_next = BK_IDLE;
                        else
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            addr_next  = STAT_AW'(NUM_VALS);
                            state_next = BK_C_ROW;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = BK_M_RD;
                    end
                end
            end
            BK_C_ROW:
            begin
                dv_rd_en   = 1'b1;
                dv_rd_addr = row_reg;
                state_next = BK_C_ROWL;
            end
            BK_C_ROWL:
            begin
                da_next    = $signed(dv_rd_data);
                state_next = BK_C_RD;
            end
            BK_C_RD:
            begin
                dv_rd_en   = 1'b1;
                dv_rd_addr = DEV_AW'(col_reg);
                st_rd_en   = 1'b1;
                state_next = BK_C_MUL;
            end
            BK_C_MUL:
            begin
                prod_next  = da_reg * $signed(dv_rd_data);
                c_next     = stat_q;
                state_next = BK_C_D1;
            end
            BK_C_D1:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(prod_mag >> 16);
                div_divisor  = n_reg - 1'b1;
                div_neg      = prod_reg[63];
                state_next   = BK_C_W1;
            end
            BK_C_W1:
            begin
                if (div_done)
                begin
                    t1_next    = div_quot;
                    state_next = BK_C_D2;
                end
            end
            BK_C_D2:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(c_mag);
                div_neg      = c_reg[STAT_W-1];
                state_next   = BK_C_W2;
            end
            BK_C_W2:
            begin
                if (div_done)
                begin
                    st_wr_en   = 1'b1;
                    st_wr_data = sat_stat({{5{c_reg[STAT_W-1]}}, c_reg}
                                          + {{2{t1_reg[DIV_W]}}, t1_reg}
                                          - {{2{div_quot[DIV_W]}}, div_quot});
                    valid_next[addr_reg] = 1'b1;
                    addr_next  = addr_reg + 1'b1;
                    if (col_reg == COL_W'(NUM_COORDS - 1))
                    begin
                        col_next = '0;
                        if (row_reg == DEV_AW'(NUM_VALS - 1))
                            state_next = BK_IDLE;
                        else
                        begin
                            row_next   = row_reg + 1'b1;
                            state_next = BK_C_ROW;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = BK_C_RD;
                    end
                end
            end
            BK_R_ISSUE:
            begin
                if (out_free)
                begin
                    st_rd_en   = 1'b1;
                    state_next = BK_R_LOAD;
                end
            end
            BK_R_LOAD:
            begin
                out_load = 1'b1;
                if (addr_reg == STAT_AW'(NUM_STATS - 1))
                    state_next = BK_IDLE;
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = BK_R_ISSUE;
                end
            end
            default:
                state_next = BK_IDLE;
        endcase
        if (out_load)
            ov_next = 1'b1;
        else if (ov_reg && out_ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        addr_reg <= addr_next;
        old_reg  <= old_next;
        da_reg   <= da_next;
        prod_reg <= prod_next;
        c_reg    <= c_next;
        t1_reg   <= t1_next;
        if (st_rd_en)
            rdv_reg <= valid_reg[st_rd_addr];
        if (out_load)
        begin
            oidx_reg  <= IDX_W'(addr_reg);
            oval_reg  <= stat_q;
            otot_reg  <= cnt_reg;
            olast_reg <= (addr_reg == STAT_AW'(NUM_STATS - 1));
        end
    end

    assign out_valid    = ov_reg;
    assign stat_index   = oidx_reg;
    assign stat_value   = oval_reg;
    assign sample_total = otot_reg;
    assign last         = olast_reg;
endmodule
`default_nettype wire

// File: sv/running_mean_covariance_top.sv
// Top level of the running mean and covariance block.
//
//  channel   direction  beat carries
//  in        into       command, var_0..var_5, par_0..par_1
//  out       out of     stat_index, stat_value, sample_total, last
//
// Accumulate: paced by the shared divider (one quotient bit per cycle, 50 quotient bits
// per division; 8 mean divisions per sample, plus 96 covariance divisions from the second
// sample on). Readout: 56 beats, each read and then registered. Two input beats queue while
// work runs. Reset clears the count and the statistics' valid bits; no clearing pass.
// A stalled output holds a readout in progress; the input queue keeps accepting until full.
`default_nettype none
module running_mean_covariance_top import rmc_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     command,
    input  wire logic signed [VAL_W-1:0]  var_0,
    input  wire logic signed [VAL_W-1:0]  var_1,
    input  wire logic signed [VAL_W-1:0]  var_2,
    input  wire logic signed [VAL_W-1:0]  var_3,
    input  wire logic signed [VAL_W-1:0]  var_4,
    input  wire logic signed [VAL_W-1:0]  var_5,
    input  wire logic signed [VAL_W-1:0]  par_0,
    input  wire logic signed [VAL_W-1:0]  par_1,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [IDX_W-1:0]              stat_index,
    output logic signed [STAT_W-1:0]      stat_value,
    output logic [CNT_W-1:0]              sample_total,
    output logic                          last
);
    logic [NUM_VALS-1:0][VAL_W-1:0] vals;
    logic                           q_valid;
    logic                           q_pop;
    item_t                          q_item;

    assign vals = {par_1, par_0, var_5, var_4, var_3, var_2, var_1, var_0};

    rmc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .vals     (vals),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    rmc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .stat_index   (stat_index),
        .stat_value   (stat_value),
        .sample_total (sample_total),
        .last         (last)
    );
endmodule
`default_nettype wire

// File: sv/rmc_checker.sv
// Port-level checks of the running mean and covariance block, bound to the top level.
`default_nettype none
`include "running_mean_covariance_top_defines.svh"
module rmc_checker import rmc_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [IDX_W-1:0]  stat_index,
    input wire logic [STAT_W-1:0] stat_value,
    input wire logic [CNT_W-1:0]  sample_total,
    input wire logic              last
);
    `RMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(stat_value) && $stable(stat_index) && $stable(sample_total) && $stable(last), "output beat changed while stalled")
    `RMC_ASSERT_NOW(a_index_range, out_valid, stat_index <= IDX_W'(NUM_STATS - 1), "statistic index out of range")
    `RMC_ASSERT_NOW(a_last_index, out_valid && last, stat_index == IDX_W'(NUM_STATS - 1), "last flag on wrong statistic")
endmodule

bind running_mean_covariance_top rmc_checker u_rmc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat_index   (stat_index),
    .stat_value   (stat_value),
    .sample_total (sample_total),
    .last         (last)
);
`default_nettype wire
